// ===== src/pmc_pkg.sv =====
// pmc_pkg: shared constants, opcodes and coordinate helper functions
// for the ps/2 mouse packet cursor block; no dependencies
`default_nettype none

package pmc_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int SIZE_WIDTH      = 13;
  localparam int BYTE_WIDTH      = 8;
  localparam int BTN_WIDTH       = 3;
  localparam int LIM_WIDTH       = 16;

  localparam logic [SIZE_WIDTH-1:0] RESET_SCREEN_WIDTH  = 13'd800;
  localparam logic [SIZE_WIDTH-1:0] RESET_SCREEN_HEIGHT = 13'd600;

  localparam logic [BYTE_WIDTH-1:0] SYNC_BIT    = 8'h08;
  localparam logic [BYTE_WIDTH-1:0] BUTTON_MASK = 8'h07;

  localparam logic [1:0] OP_BYTE     = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_RECENTRE = 2'd2;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef logic signed [BYTE_WIDTH:0] delta_t;

  // largest coordinate for a screen size, capped at cmax; zero size pins the axis to 0
  function automatic logic [LIM_WIDTH-1:0] axis_limit(
    input logic [SIZE_WIDTH-1:0] size,
    input logic [LIM_WIDTH-1:0]  cmax
  );
    logic [LIM_WIDTH-1:0] lim;
    lim = (size == '0) ? '0 : LIM_WIDTH'(size) - LIM_WIDTH'(1);
    return (lim > cmax) ? cmax : lim;
  endfunction

  function automatic logic [LIM_WIDTH-1:0] centre_of(
    input logic [SIZE_WIDTH-1:0] size,
    input logic [LIM_WIDTH-1:0]  cmax
  );
    logic [LIM_WIDTH-1:0] c;
    logic [LIM_WIDTH-1:0] lim;
    c   = LIM_WIDTH'(size >> 1);
    lim = axis_limit(size, cmax);
    return (c > lim) ? lim : c;
  endfunction

endpackage

`default_nettype wire

// ===== src/pmc_if.sv =====
// pmc_if: valid/ready channel interfaces for requests, results and
// configuration writes; depends on nothing
`default_nettype none

interface pmc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic       from_aux;

  modport source (output valid, opcode, rx_byte, from_aux, input ready);
  modport sink   (input valid, opcode, rx_byte, from_aux, output ready);
endinterface

interface pmc_rsp_if #(parameter int CoordWidth = 12);
  logic                  valid;
  logic                  ready;
  logic [CoordWidth-1:0] cursor_x;
  logic [CoordWidth-1:0] cursor_y;
  logic [2:0]            button_bits;
  logic                  moved_flag;
  logic                  packet_done;

  modport source (output valid, cursor_x, cursor_y, button_bits, moved_flag, packet_done,
                  input ready);
  modport sink   (input valid, cursor_x, cursor_y, button_bits, moved_flag, packet_done,
                  output ready);
endinterface

interface pmc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/pmc_axis.sv =====
// pmc_axis: one cursor axis, moves by a signed delta with clamping and
// gives the recentre position; depends on pmc_pkg
`default_nettype none

module pmc_axis
  import pmc_pkg::*;
#(
  parameter int CoordWidth = COORD_WIDTH_DEF
) (
  input  wire logic [CoordWidth-1:0] pos,
  input  wire delta_t                delta,
  input  wire logic [SIZE_WIDTH-1:0] size,
  output logic      [CoordWidth-1:0] moved,
  output logic      [CoordWidth-1:0] centre
);

  localparam int SumWidth = LIM_WIDTH + 2;
  localparam logic [LIM_WIDTH-1:0] Cmax = LIM_WIDTH'((32'd1 << CoordWidth) - 32'd1);

  logic [LIM_WIDTH-1:0]       lim;
  logic [LIM_WIDTH-1:0]       ctr;
  logic signed [SumWidth-1:0] sum;
  logic signed [SumWidth-1:0] lim_s;

  always_comb begin
    lim   = axis_limit(size, Cmax);
    ctr   = centre_of(size, Cmax);
    sum   = $signed({2'b00, LIM_WIDTH'(pos)})
          + $signed({{(SumWidth-BYTE_WIDTH-1){delta[BYTE_WIDTH]}}, delta});
    lim_s = $signed({2'b00, lim});
    if (sum < 0) begin
      moved = '0;
    end else if (sum > lim_s) begin
      moved = lim[CoordWidth-1:0];
    end else begin
      moved = sum[CoordWidth-1:0];
    end
    centre = ctr[CoordWidth-1:0];
  end

endmodule

`default_nettype wire

// ===== src/ps2_mouse_packet_cursor.sv =====
// ps2_mouse_packet_cursor: three-byte mouse packet decoder with a clamped cursor
// result: registered, valid in the cycle after the request is accepted
// throughput: one request per cycle, the single result register sets the pace
// a stalled result holds the request side off until it is taken
// reset: sizes 800 x 600, cursor at the centre, buttons, flag and phase cleared
// depends on pmc_pkg, pmc_if and pmc_axis
`default_nettype none

module ps2_mouse_packet_cursor
  import pmc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pmc_req_if.sink   req,
  pmc_rsp_if.source rsp,
  pmc_cfg_if.sink   cfg
);

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_X     = 2'd1;
  localparam logic [1:0] PH_Y     = 2'd2;

  localparam logic [LIM_WIDTH-1:0] Cmax = LIM_WIDTH'((32'd1 << COORD_WIDTH) - 32'd1);
  localparam logic [LIM_WIDTH-1:0] ResetCx = centre_of(RESET_SCREEN_WIDTH, Cmax);
  localparam logic [LIM_WIDTH-1:0] ResetCy = centre_of(RESET_SCREEN_HEIGHT, Cmax);

  logic [SIZE_WIDTH-1:0]  screen_width;
  logic [SIZE_WIDTH-1:0]  screen_height;
  logic [1:0]             phase, phase_next;
  logic [BTN_WIDTH-1:0]   first_buttons, first_buttons_next;
  logic [BYTE_WIDTH-1:0]  delta_x_byte, delta_x_byte_next;
  logic [COORD_WIDTH-1:0] pos_x, pos_x_next;
  logic [COORD_WIDTH-1:0] pos_y, pos_y_next;
  logic [BTN_WIDTH-1:0]   buttons, buttons_next;
  logic                   moved, moved_next;
  logic                   done, done_next;
  logic                   out_valid;

  logic                   accept;
  delta_t                 dx, dy;
  logic [COORD_WIDTH-1:0] x_moved, x_centre, y_moved, y_centre;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  assign dx = $signed({delta_x_byte[BYTE_WIDTH-1], delta_x_byte});
  assign dy = -$signed({req.rx_byte[BYTE_WIDTH-1], req.rx_byte});

  pmc_axis #(.CoordWidth(COORD_WIDTH)) u_axis_x (
    .pos    (pos_x),
    .delta  (dx),
    .size   (screen_width),
    .moved  (x_moved),
    .centre (x_centre)
  );

  pmc_axis #(.CoordWidth(COORD_WIDTH)) u_axis_y (
    .pos    (pos_y),
    .delta  (dy),
    .size   (screen_height),
    .moved  (y_moved),
    .centre (y_centre)
  );

  always_comb begin
    phase_next         = phase;
    first_buttons_next = first_buttons;
    delta_x_byte_next  = delta_x_byte;
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    buttons_next       = buttons;
    moved_next         = moved;
    done_next          = 1'b0;
    case (req.opcode)
      OP_BYTE: begin
        if (req.from_aux) begin
          case (phase)
            PH_FIRST: begin
              first_buttons_next = req.rx_byte[BTN_WIDTH-1:0] & BUTTON_MASK[BTN_WIDTH-1:0];
              if ((req.rx_byte & SYNC_BIT) != '0) begin
                phase_next = PH_X;
              end
            end
            PH_X: begin
              delta_x_byte_next = req.rx_byte;
              phase_next        = PH_Y;
            end
            default: begin
              buttons_next = first_buttons;
              pos_x_next   = x_moved;
              pos_y_next   = y_moved;
              moved_next   = 1'b1;
              phase_next   = PH_FIRST;
              done_next    = 1'b1;
            end
          endcase
        end
      end
      OP_CLEAR: begin
        moved_next = 1'b0;
      end
      OP_RECENTRE: begin
        pos_x_next         = x_centre;
        pos_y_next         = y_centre;
        buttons_next       = '0;
        moved_next         = 1'b0;
        phase_next         = PH_FIRST;
        first_buttons_next = '0;
        delta_x_byte_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_SCREEN_WIDTH;
      screen_height <= RESET_SCREEN_HEIGHT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
        REG_SCREEN_HEIGHT: screen_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      first_buttons <= '0;
      delta_x_byte  <= '0;
      pos_x         <= ResetCx[COORD_WIDTH-1:0];
      pos_y         <= ResetCy[COORD_WIDTH-1:0];
      buttons       <= '0;
      moved         <= 1'b0;
      done          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        first_buttons <= first_buttons_next;
        delta_x_byte  <= delta_x_byte_next;
        pos_x         <= pos_x_next;
        pos_y         <= pos_y_next;
        buttons       <= buttons_next;
        moved         <= moved_next;
        done          <= done_next;
        out_valid     <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result fields are the state left by the last request, held while stalled
  assign rsp.valid       = out_valid;
  assign rsp.cursor_x    = pos_x;
  assign rsp.cursor_y    = pos_y;
  assign rsp.button_bits = buttons;
  assign rsp.moved_flag  = moved;
  assign rsp.packet_done = done;

endmodule

`default_nettype wire
